// ===== sv/egcd_pkg.sv =====
package egcd_pkg;

  // sequencer states of the gcd engine
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHK,
    ST_DIV,
    ST_UPD,
    ST_FIN
  } egcd_state_t;

endpackage

// ===== sv/extended_gcd_bezout_coefficients.sv =====
// the time from accept to result valid grows with k, the number of quotient steps
// (k <= 45 at 31 bits); one item is worked on at a time
// each quotient step runs the bit-serial divider, which sets the pace between items
// a new item is taken while the previous result still waits in the output register
// reset: rst_n synchronous active low clears the sequencer and the output valid flag
module extended_gcd_bezout_coefficients #(
  parameter int OPERAND_WIDTH = 31
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [OPERAND_WIDTH-1:0]        in_modulus,
  input  logic [OPERAND_WIDTH-1:0]        in_value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [OPERAND_WIDTH-1:0]        out_gcd_out,
  output logic signed [OPERAND_WIDTH:0]   out_coef_modulus,
  output logic signed [OPERAND_WIDTH:0]   out_coef_value
);

  localparam int W     = OPERAND_WIDTH;
  localparam int CNT_W = $clog2(W);

  egcd_pkg::egcd_state_t state_r, state_nxt;

  // two remainder rows: prev (dividend) and cur (divisor)
  logic [W-1:0] prev_r_r, cur_r_r;
  // coefficient rows, kept modulo 2^(W+1); final values fit in that range
  logic [W:0]   prev_x_r, cur_x_r, prev_y_r, cur_y_r;

  // bit-serial divider: partial remainder and dividend shift register
  logic [W-1:0] rem_r;
  logic [W-1:0] dq_r;
  logic [CNT_W-1:0] cnt_r;
  // quotient times current coefficient, built msb first by shift and add
  logic [W:0]   px_r, py_r;

  // output register
  logic         out_valid_r;
  logic [W-1:0] gcd_r;
  logic [W:0]   cm_r, cv_r;

  logic         accept;
  logic         out_free;
  logic         last_bit;

  // one restoring division step
  logic [W:0]   trial;
  logic [W:0]   diff;
  logic         q_bit;
  logic [W-1:0] rem_nxt;
  logic [W:0]   px_nxt, py_nxt;

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign last_bit = (cnt_r == CNT_W'(W - 1));

  always_comb begin
    trial   = {rem_r, dq_r[W-1]};
    diff    = trial - {1'b0, cur_r_r};
    q_bit   = (trial >= {1'b0, cur_r_r});
    rem_nxt = q_bit ? diff[W-1:0] : trial[W-1:0];
    px_nxt  = {px_r[W-1:0], 1'b0} + (q_bit ? cur_x_r : '0);
    py_nxt  = {py_r[W-1:0], 1'b0} + (q_bit ? cur_y_r : '0);
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= egcd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    case (state_r)
      egcd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = egcd_pkg::ST_CHK;
        end
      end
      egcd_pkg::ST_CHK: begin
        // zero remainder ends the algorithm, prev row holds the answer
        if (cur_r_r == '0) begin
          state_nxt = egcd_pkg::ST_FIN;
        end else begin
          state_nxt = egcd_pkg::ST_DIV;
        end
      end
      egcd_pkg::ST_DIV: begin
        if (last_bit) begin
          state_nxt = egcd_pkg::ST_UPD;
        end
      end
      egcd_pkg::ST_UPD: begin
        state_nxt = egcd_pkg::ST_CHK;
      end
      egcd_pkg::ST_FIN: begin
        if (out_free) begin
          state_nxt = egcd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = egcd_pkg::ST_IDLE;
      end
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      egcd_pkg::ST_IDLE: begin
        if (in_valid) begin
          prev_r_r <= in_modulus;
          cur_r_r  <= in_value;
          prev_x_r <= (W+1)'(1);
          cur_x_r  <= '0;
          prev_y_r <= '0;
          cur_y_r  <= (W+1)'(1);
        end
      end
      egcd_pkg::ST_CHK: begin
        rem_r <= '0;
        dq_r  <= prev_r_r;
        px_r  <= '0;
        py_r  <= '0;
        cnt_r <= '0;
      end
      egcd_pkg::ST_DIV: begin
        rem_r <= rem_nxt;
        dq_r  <= {dq_r[W-2:0], 1'b0};
        px_r  <= px_nxt;
        py_r  <= py_nxt;
        cnt_r <= cnt_r + CNT_W'(1);
      end
      egcd_pkg::ST_UPD: begin
        // next row = previous row minus quotient times current row
        prev_r_r <= cur_r_r;
        cur_r_r  <= rem_r;
        prev_x_r <= cur_x_r;
        cur_x_r  <= prev_x_r - px_r;
        prev_y_r <= cur_y_r;
        cur_y_r  <= prev_y_r - py_r;
      end
      default: begin
      end
    endcase
  end

  // output register, separate from the engine so a new item can start
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == egcd_pkg::ST_FIN && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == egcd_pkg::ST_FIN && out_free) begin
      gcd_r <= prev_r_r;
      cm_r  <= prev_x_r;
      cv_r  <= prev_y_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_gcd_out      = gcd_r;
  assign out_coef_modulus = $signed(cm_r);
  assign out_coef_value   = $signed(cv_r);

  // divider never runs with a zero divisor
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == egcd_pkg::ST_DIV |-> cur_r_r != '0)
    else $error("division started with zero divisor");

  // remainder after a full division is below the divisor
  a_rem_lt_div: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == egcd_pkg::ST_UPD |-> rem_r < cur_r_r)
    else $error("remainder not below divisor");

  // an accepted item starts the engine
  a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == egcd_pkg::ST_CHK)
    else $error("accepted item did not start the engine");

  // a finished result is loaded into the output register
  a_fin_load: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == egcd_pkg::ST_FIN && out_free |=> out_valid_r && state_r == egcd_pkg::ST_IDLE)
    else $error("finished result not presented");

endmodule

// ===== bench/extended_gcd_bezout_coefficients_tb.sv =====
module extended_gcd_bezout_coefficients_tb;

  localparam int OPW = 31;
  localparam int CLK_HALF = 6;
  // settle time, covering the longest pass through the engine at 45 quotient steps
  localparam int SETTLE_CYCLES = 1600;
  localparam int CYCLE_LIMIT = 4000000;

  // one result item as the block should deliver it
  typedef struct packed {
    logic [OPW-1:0] gcd;
    logic [OPW:0]   coef_m;
    logic [OPW:0]   coef_v;
  } bezout_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [OPW-1:0] in_modulus = '0;
  logic [OPW-1:0] in_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [OPW-1:0] out_gcd_out;
  logic signed [OPW:0] out_coef_modulus;
  logic signed [OPW:0] out_coef_value;

  // results still owed by the block, oldest first
  bezout_t owed_results[$];

  // idling controls, in percent of cycles
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // run bookkeeping
  int cycle_count = 0;
  int mismatches = 0;
  int items_sent = 0;
  int results_checked = 0;
  int coprime_results = 0;
  int longest_chain = 0;

  extended_gcd_bezout_coefficients #(
    .OPERAND_WIDTH(OPW)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_modulus(in_modulus),
    .in_value(in_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_gcd_out(out_gcd_out),
    .out_coef_modulus(out_coef_modulus),
    .out_coef_value(out_coef_value)
  );

  always #CLK_HALF clk = ~clk;

  // free-running cycle count for the watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // receiver: random back-pressure at the current stall rate
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // extended euclid on two rows (coef of m, remainder, coef of v), wrapping at 64 bits
  // the same way a fixed-width datapath would, then cut to the output widths
  function automatic bezout_t bezout_predict(input logic [OPW-1:0] m, input logic [OPW-1:0] v,
                                             output int steps);
    logic [63:0] r_prev, r_cur, x_prev, x_cur, y_prev, y_cur, quot, nxt;
    bezout_t res;
    r_prev = 64'(m);
    r_cur = 64'(v);
    x_prev = 64'd1;
    x_cur = 64'd0;
    y_prev = 64'd0;
    y_cur = 64'd1;
    steps = 0;
    while (r_cur != 64'd0) begin
      quot = r_prev / r_cur;
      nxt = r_prev - quot * r_cur;
      r_prev = r_cur;
      r_cur = nxt;
      nxt = x_prev - quot * x_cur;
      x_prev = x_cur;
      x_cur = nxt;
      nxt = y_prev - quot * y_cur;
      y_prev = y_cur;
      y_cur = nxt;
      steps++;
    end
    res.gcd = r_prev[OPW-1:0];
    res.coef_m = x_prev[OPW:0];
    res.coef_v = y_prev[OPW:0];
    return res;
  endfunction

  // prints one line per mismatch and counts every one
  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  // offer one item, holding valid and payload until the handshake; valid is left high
  // so that a following item can go out back to back without a dip
  task automatic send_operands(input logic [OPW-1:0] m, input logic [OPW-1:0] v);
    bezout_t want;
    int steps;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_modulus <= m;
    in_value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // item taken at this edge: record what it should produce
    want = bezout_predict(m, v, steps);
    owed_results.push_back(want);
    items_sent++;
    if (steps > longest_chain) longest_chain = steps;
  endtask

  // result checker: every accepted result against the oldest expectation
  always @(posedge clk) begin
    bezout_t want;
    if (rst_n && out_valid && out_ready) begin
      if (owed_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result gcd=%0d x=%0d y=%0d",
                                  out_gcd_out, out_coef_modulus, out_coef_value));
      end else begin
        want = owed_results.pop_front();
        results_checked++;
        if (want.gcd == OPW'(1)) coprime_results++;
        if (out_gcd_out !== want.gcd)
          report_mismatch($sformatf("result %0d gcd %0d, expected %0d",
                                    results_checked, out_gcd_out, want.gcd));
        if (out_coef_modulus !== want.coef_m)
          report_mismatch($sformatf("result %0d modulus coef %0d, expected %0d",
                                    results_checked, out_coef_modulus,
                                    $signed(want.coef_m)));
        if (out_coef_value !== want.coef_v)
          report_mismatch($sformatf("result %0d value coef %0d, expected %0d",
                                    results_checked, out_coef_value,
                                    $signed(want.coef_v)));
      end
    end
  end

  // zero operands: no quotient step, or a single trivial one
  task automatic test_zero_operands();
    send_operands('0, '0);
    send_operands(OPW'(12345), '0);
    send_operands('1, '0);
    send_operands('0, OPW'(987654));
    send_operands('0, '1);
    send_operands('0, OPW'(1));
  endtask

  // field extremes, equal operands, ones, and both operand orders
  task automatic test_extreme_operands();
    send_operands('1, '1);
    send_operands('1, OPW'(1));
    send_operands(OPW'(1), '1);
    send_operands(OPW'(1), OPW'(1));
    send_operands(OPW'(2147483629), OPW'(65537));   // prime modulus, inverse exists
    send_operands(OPW'(65537), OPW'(2147483629));   // value larger than modulus
    send_operands(OPW'(32'h5555_5555), OPW'(32'h2AAA_AAAA));
    send_operands(OPW'(32'h2AAA_AAAA), OPW'(32'h5555_5555));
    send_operands(OPW'(1 << (OPW - 1)), OPW'(1 << (OPW - 2)));
    send_operands(OPW'(600), OPW'(360));            // common factor, gcd above one
  endtask

  // consecutive fibonacci numbers give the longest remainder chains at this width
  task automatic test_long_remainder_chains();
    logic [OPW-1:0] fib_a, fib_b, fib_c;
    fib_a = OPW'(1);
    fib_b = OPW'(1);
    // step up to fib(46), the largest that fits in 31 bits
    repeat (44) begin
      fib_c = fib_a + fib_b;
      fib_a = fib_b;
      fib_b = fib_c;
    end
    send_operands(fib_b, fib_a);
    send_operands(fib_a, fib_b);
    send_operands(fib_b, fib_b - fib_a);
    send_operands(fib_b - fib_a, fib_a);
  endtask

  // random operand cut to the given bit width; the callers shape it for small chains, common factors and full width
  function automatic logic [OPW-1:0] rand_operand(input int width);
    logic [31:0] raw;
    raw = $urandom;
    if (width < OPW) raw = raw & ((32'd1 << width) - 32'd1);
    return raw[OPW-1:0];
  endfunction

  task automatic test_random_traffic(input int count, input int idle_pct, input int stall_pct);
    logic [OPW-1:0] m, v, factor;
    int pick;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 6) begin
        // one operand zero
        m = rand_operand($urandom_range(1, OPW));
        v = rand_operand($urandom_range(1, OPW));
        if (pick < 3) m = '0;
        else v = '0;
      end else if (pick < 18) begin
        // shared factor so the gcd is above one
        factor = OPW'($urandom_range(2, 5000));
        m = factor * rand_operand($urandom_range(1, 18));
        v = factor * rand_operand($urandom_range(1, 18));
      end else if (pick < 28) begin
        // full width, every bit free
        m = rand_operand(OPW);
        v = rand_operand(OPW);
      end else if (pick < 32) begin
        m = rand_operand($urandom_range(1, OPW));
        v = m;
      end else begin
        // mostly short chains to keep the run brisk
        m = rand_operand($urandom_range(1, OPW));
        v = rand_operand($urandom_range(1, 20));
      end
      send_operands(m, v);
    end
  endtask

  // watchdog: a hung handshake ends the run here
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles, %0d results still owed", cycle_count,
             owed_results.size());
    $display("extended_gcd_bezout_coefficients_tb NOT OK");
    $finish;
  end

  initial begin
    // reset held low at the start, then released on a clock edge
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part runs with no idling on either side
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_zero_operands();
    test_extreme_operands();
    test_long_remainder_chains();

    // random part through the idling phases
    test_random_traffic(100, 0, 0);
    test_random_traffic(100, 56, 0);
    test_random_traffic(100, 0, 56);
    test_random_traffic(100, 19, 19);

    in_valid <= 1'b0;
    recv_stall_pct = 0;
    while (owed_results.size() != 0) @(posedge clk);
    // watch for stray results after the last one
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (owed_results.size() != 0) report_mismatch("results still owed at the end");
    $display("sent %0d operand pairs, checked %0d results in %0d cycles", items_sent,
             results_checked, cycle_count);
    $display("%0d coprime results, longest chain %0d quotient steps, %0d mismatches",
             coprime_results, longest_chain, mismatches);
    if (mismatches == 0) begin
      $display("extended_gcd_bezout_coefficients_tb OK");
    end else begin
      $display("extended_gcd_bezout_coefficients_tb NOT OK");
    end
    $finish;
  end

endmodule
